// ===== rtl/core/cmtp_pkg.sv =====
// ----------------------------------------------------------------------------
// cmtp_pkg
// Shared types and constants of the control message TLV parser: token
// layout, token kinds, status codes and the sizes of the frame headers.
// ----------------------------------------------------------------------------
`default_nettype none

package cmtp_pkg;

  // Frame and parameter header sizes in bytes
  localparam logic [15:0] HDR_SIZE  = 16'd6;
  localparam logic [15:0] PHDR_SIZE = 16'd4;

  // Token queue depth; must hold the two tokens one byte can raise
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef enum logic [1:0] {
    KIND_HDR    = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  // Frame status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SHORT      = 3'd1;
  localparam logic [2:0] ST_BAD_MARKER = 3'd2;
  localparam logic [2:0] ST_BAD_LEN    = 3'd3;
  localparam logic [2:0] ST_TRUNC_PHDR = 3'd4;
  localparam logic [2:0] ST_BAD_PLEN   = 3'd5;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] message_id;
    logic [15:0] param_id;
    logic [15:0] param_data_length;
    logic [7:0]  param_byte;
    logic [15:0] byte_index;
    logic        param_last;
    logic [2:0]  status;
    logic        frame_done;
  } token_t;

  // Token queue status seen by the parser and the output port
  typedef struct packed {
    logic not_empty;
    logic no_room;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/cmtp_token_fifo.sv =====
// ----------------------------------------------------------------------------
// cmtp_token_fifo
// Small token queue between the parser and the result channel. Takes up to
// two tokens per cycle in order, hands out one per cycle from its head while pop is high.
// ----------------------------------------------------------------------------
`default_nettype none

module cmtp_token_fifo (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push0_v,
  input  wire cmtp_pkg::token_t push0,
  input  wire                  push1_v,
  input  wire cmtp_pkg::token_t push1,
  input  wire                  pop,
  output cmtp_pkg::token_t     head,
  output cmtp_pkg::fifo_stat_t stat
);
  import cmtp_pkg::*;

  token_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]   count_r, count_nxt;
  logic [FIFO_CNT_W-1:0]   npush;
  logic [FIFO_PTR_W-1:0]   wr_ptr_inc;
  token_t                  first_tok;

  assign npush      = FIFO_CNT_W'(push0_v) + FIFO_CNT_W'(push1_v);
  assign wr_ptr_inc = wr_ptr_r + FIFO_PTR_W'(1);
  assign first_tok  = push0_v ? push0 : push1;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + npush[FIFO_PTR_W-1:0];
    rd_ptr_nxt = pop ? rd_ptr_r + FIFO_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + npush - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store incoming tokens in arrival order
  always_ff @(posedge clk) begin
    if (push0_v || push1_v) begin
      mem_r[wr_ptr_r] <= first_tok;
    end
    if (push0_v && push1_v) begin
      mem_r[wr_ptr_inc] <= push1;
    end
  end

  assign head           = mem_r[rd_ptr_r];
  assign stat.not_empty = (count_r != '0);
  assign stat.no_room   = (count_r > FIFO_CNT_W'(FIFO_DEPTH - 2));

endmodule

`default_nettype wire

// ===== rtl/core/control_message_tlv_parser.sv =====
// ----------------------------------------------------------------------------
// control_message_tlv_parser
// Walks the 6-byte header and the parameter records of a control message
// frame and emits parameter header, data byte and frame status tokens.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one frame byte per transaction, in_frame_last on the final byte.
//   out_* : one token per transaction; a nonzero out_status on the token with
//           out_frame_done tells the receiver to discard the frame's tokens.
//   cfg_* : writes the expected start word; cfg_ready is always high, write
//           only while no frame is in flight.
//   Each accepted byte updates the parser state in the same cycle and puts
//   zero, one or two tokens into a four-entry token queue; the tokens are
//   registered there and appear on out_* from the head of the queue.
//   While in_stall is low the parser takes one byte per cycle; a frame's
//   final byte may raise two tokens, which the one-token-per-cycle result
//   port drains in turn while out_stall is low.
//   in_stall rises when the queue has fewer than two free entries, so a
//   stalled receiver holds back the input once the queue holds three tokens.
//   Reset empties the queue, clears the frame state and sets the start word
//   to 0x4040.
// ----------------------------------------------------------------------------
`default_nettype none

module control_message_tlv_parser (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_frame_last,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_token_kind,
  output logic [15:0] out_message_id,
  output logic [15:0] out_param_id,
  output logic [15:0] out_param_data_length,
  output logic [7:0]  out_param_byte,
  output logic [15:0] out_byte_index,
  output logic        out_param_last,
  output logic [2:0]  out_status,
  output logic        out_frame_done,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [15:0] cfg_data
);
  import cmtp_pkg::*;

  logic [15:0] start_r;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] marker_r, marker_nxt;
  logic [15:0] total_r, total_nxt;
  logic [15:0] mid_r, mid_nxt;
  logic [31:0] phdr_r, phdr_nxt;
  logic [2:0]  pfill_r, pfill_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [2:0]  err_r, err_nxt;

  logic        accept;
  logic        walk_en;
  logic [15:0] body_left;
  logic [16:0] avail;
  logic [31:0] phdr_shift;
  logic [15:0] ptotal;
  token_t      tok0, tok1, head;
  logic        tok0_v;
  fifo_stat_t  fstat;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = fstat.no_room;
  assign cfg_ready  = 1'b1;

  assign walk_en    = (marker_r == start_r) && (cnt_r < total_r) && (err_r == ST_OK);
  assign body_left  = total_r - cnt_r;
  assign avail      = {1'b0, body_left} + 17'd3;
  assign phdr_shift = {phdr_r[23:0], in_data_byte};
  assign ptotal     = phdr_shift[31:16];

  // Parse one byte: header capture, parameter walk, frame close
  always_comb begin
    marker_nxt = marker_r;
    total_nxt  = total_r;
    mid_nxt    = mid_r;
    phdr_nxt   = phdr_r;
    pfill_nxt  = pfill_r;
    left_nxt   = left_r;
    pos_nxt    = pos_r;
    err_nxt    = err_r;
    tok0       = '0;
    tok0_v     = 1'b0;
    tok1       = '0;

    if (cnt_r < 16'd2) begin
      marker_nxt = {marker_r[7:0], in_data_byte};
    end else if (cnt_r < 16'd4) begin
      total_nxt = {total_r[7:0], in_data_byte};
    end else if (cnt_r < HDR_SIZE) begin
      mid_nxt = {mid_r[7:0], in_data_byte};
    end else if (walk_en) begin
      if (left_r != 16'd0) begin
        tok0_v                 = 1'b1;
        tok0.kind              = KIND_DATA;
        tok0.message_id        = mid_r;
        tok0.param_id          = phdr_r[15:0];
        tok0.param_data_length = phdr_r[31:16] - PHDR_SIZE;
        tok0.param_byte        = in_data_byte;
        tok0.byte_index        = pos_r;
        tok0.param_last        = (left_r == 16'd1);
        left_nxt               = left_r - 16'd1;
        pos_nxt                = pos_r + 16'd1;
      end else if (pfill_r == 3'd0) begin
        if (body_left < PHDR_SIZE) begin
          err_nxt = ST_TRUNC_PHDR;
        end else begin
          phdr_nxt  = {24'd0, in_data_byte};
          pfill_nxt = 3'd1;
        end
      end else begin
        phdr_nxt  = phdr_shift;
        pfill_nxt = pfill_r + 3'd1;
        if (pfill_r == 3'd3) begin
          pfill_nxt = 3'd0;
          if ((ptotal < PHDR_SIZE) || ({1'b0, ptotal} > avail)) begin
            err_nxt = ST_BAD_PLEN;
          end else begin
            left_nxt               = ptotal - PHDR_SIZE;
            pos_nxt                = 16'd0;
            tok0_v                 = 1'b1;
            tok0.kind              = KIND_HDR;
            tok0.message_id        = mid_r;
            tok0.param_id          = phdr_shift[15:0];
            tok0.param_data_length = ptotal - PHDR_SIZE;
          end
        end
      end
    end

    // Saturating byte count
    cnt_nxt = (cnt_r == 16'hFFFF) ? cnt_r : cnt_r + 16'd1;

    // Close the frame: status by priority, then clear for the next one
    if (in_frame_last) begin
      tok1.kind       = KIND_STATUS;
      tok1.frame_done = 1'b1;
      tok1.message_id = mid_nxt;
      if (cnt_nxt < HDR_SIZE) begin
        tok1.status     = ST_SHORT;
        tok1.message_id = 16'd0;
      end else if (marker_nxt != start_r) begin
        tok1.status = ST_BAD_MARKER;
      end else if ((total_nxt < HDR_SIZE) || (total_nxt > cnt_nxt)) begin
        tok1.status = ST_BAD_LEN;
      end else begin
        tok1.status = err_nxt;
      end
      cnt_nxt    = '0;
      marker_nxt = '0;
      total_nxt  = '0;
      mid_nxt    = '0;
      phdr_nxt   = '0;
      pfill_nxt  = '0;
      left_nxt   = '0;
      pos_nxt    = '0;
      err_nxt    = ST_OK;
    end
  end

  // Hold frame state; advance on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      marker_r <= '0;
      total_r  <= '0;
      mid_r    <= '0;
      phdr_r   <= '0;
      pfill_r  <= '0;
      left_r   <= '0;
      pos_r    <= '0;
      err_r    <= ST_OK;
    end else if (accept) begin
      cnt_r    <= cnt_nxt;
      marker_r <= marker_nxt;
      total_r  <= total_nxt;
      mid_r    <= mid_nxt;
      phdr_r   <= phdr_nxt;
      pfill_r  <= pfill_nxt;
      left_r   <= left_nxt;
      pos_r    <= pos_nxt;
      err_r    <= err_nxt;
    end
  end

  // Start word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 16'h4040;
    end else if (cfg_valid && cfg_ready) begin
      start_r <= cfg_data;
    end
  end

  cmtp_token_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push0_v (accept && tok0_v),
    .push0   (tok0),
    .push1_v (accept && in_frame_last),
    .push1   (tok1),
    .pop     (fstat.not_empty && !out_stall),
    .head    (head),
    .stat    (fstat)
  );

  // Present the queue head
  assign out_valid             = fstat.not_empty;
  assign out_token_kind        = head.kind;
  assign out_message_id        = head.message_id;
  assign out_param_id          = head.param_id;
  assign out_param_data_length = head.param_data_length;
  assign out_param_byte        = head.param_byte;
  assign out_byte_index        = head.byte_index;
  assign out_param_last        = head.param_last;
  assign out_status            = head.status;
  assign out_frame_done        = head.frame_done;

endmodule

`default_nettype wire

// ===== rtl/core/cmtp_checker.sv =====
// ----------------------------------------------------------------------------
// cmtp_checker
// Port-level checks of the control message TLV parser, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module cmtp_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_stall,
  input wire [1:0]  out_token_kind,
  input wire [15:0] out_param_data_length,
  input wire [15:0] out_byte_index,
  input wire        out_param_last,
  input wire [2:0]  out_status,
  input wire        out_frame_done
);
  import cmtp_pkg::*;

  // Nothing is shown straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("token shown right after reset");

  // A stalled token holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_kind)
      && $stable(out_status) && $stable(out_byte_index))
    else $error("stalled token changed");

  // Only the closing token carries status
  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind != KIND_STATUS) |-> !out_frame_done
      && (out_status == ST_OK))
    else $error("status on a non-closing token");

  // Data position stays inside the parameter and marks its last byte
  a_data_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == KIND_DATA) |->
      (out_byte_index < out_param_data_length)
      && (out_param_last == (out_byte_index == out_param_data_length - 16'd1)))
    else $error("data byte position inconsistent with parameter length");

endmodule

bind control_message_tlv_parser cmtp_checker u_cmtp_checker (.*);

`default_nettype wire

// ===== verif/control_message_tlv_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// control_message_tlv_parser_tb
// Feeds control message frames byte by byte into the TLV parser and checks
// each parameter header, data byte and frame status token against a
// behavioural predictor. Stimulus covers well-formed frames and every kind of
// broken frame under several start words, with random gaps and stalls.
// ----------------------------------------------------------------------------

module control_message_tlv_parser_tb;

  import cmtp_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       drain;  // hold this byte back until no token is due
  } byte_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_frame_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_token_kind;
  logic [15:0] out_message_id;
  logic [15:0] out_param_id;
  logic [15:0] out_param_data_length;
  logic [7:0]  out_param_byte;
  logic [15:0] out_byte_index;
  logic        out_param_last;
  logic [2:0]  out_status;
  logic        out_frame_done;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'd0;

  byte_item_t  bytes_pending[$];
  byte_item_t  byte_to_send;
  token_t      tokens_due[$];
  token_t      token_seen;
  logic [7:0]  frame_buf[$];

  bit          byte_taken = 1'b0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          tx_gap_left = 0;
  int          rx_gap_left = 0;
  bit          rx_burst;
  int          mismatches = 0;

  // Predicted parser state
  logic [15:0] start_word = 16'h4040;
  logic [15:0] seen_count = '0;
  logic [15:0] seen_marker = '0;
  logic [15:0] decl_total = '0;
  logic [15:0] msg_id = '0;
  logic [31:0] phdr = '0;
  logic [2:0]  phdr_fill = '0;
  logic [15:0] bytes_left = '0;
  logic [15:0] data_pos = '0;
  logic [2:0]  err_code = '0;

  control_message_tlv_parser u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_data_byte          (in_data_byte),
    .in_frame_last         (in_frame_last),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_token_kind        (out_token_kind),
    .out_message_id        (out_message_id),
    .out_param_id          (out_param_id),
    .out_param_data_length (out_param_data_length),
    .out_param_byte        (out_param_byte),
    .out_byte_index        (out_byte_index),
    .out_param_last        (out_param_last),
    .out_status            (out_status),
    .out_frame_done        (out_frame_done),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_data              (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic token_t form_token(kind_t k, logic [15:0] mid, logic [15:0] pid,
                                        logic [15:0] plen, logic [7:0] pbyte,
                                        logic [15:0] idx, logic plast,
                                        logic [2:0] st, logic done);
    token_t t;
    t.kind              = k;
    t.message_id        = mid;
    t.param_id          = pid;
    t.param_data_length = plen;
    t.param_byte        = pbyte;
    t.byte_index        = idx;
    t.param_last        = plast;
    t.status            = st;
    t.frame_done        = done;
    return t;
  endfunction

  // Append one predicted token
  task automatic queue_token(input token_t t);
    tokens_due = {tokens_due, t};
  endtask

  // Advance the predicted parser by one frame byte and queue its tokens
  task automatic parse_byte(input logic [7:0] b, input logic last);
    int          pos;
    int          avail;
    logic [2:0]  st;
    logic [15:0] mid;
    pos = seen_count;
    if (pos < 2) begin
      seen_marker = {seen_marker[7:0], b};
    end else if (pos < 4) begin
      decl_total = {decl_total[7:0], b};
    end else if (pos < HDR_SIZE) begin
      msg_id = {msg_id[7:0], b};
    end else if (seen_marker == start_word && pos < decl_total && err_code == ST_OK) begin
      if (bytes_left != 0) begin
        queue_token(form_token(KIND_DATA, msg_id, phdr[15:0],
                               phdr[31:16] - PHDR_SIZE, b, data_pos,
                               bytes_left == 16'd1, ST_OK, 1'b0));
        bytes_left = bytes_left - 16'd1;
        data_pos   = data_pos + 16'd1;
      end else if (phdr_fill == 0) begin
        // too few body bytes left for a parameter header
        if (int'(decl_total) - pos < int'(PHDR_SIZE)) begin
          err_code = ST_TRUNC_PHDR;
        end else begin
          phdr      = {24'd0, b};
          phdr_fill = 3'd1;
        end
      end else begin
        phdr      = {phdr[23:0], b};
        phdr_fill = phdr_fill + 3'd1;
        if (phdr_fill == PHDR_SIZE[2:0]) begin
          phdr_fill = 3'd0;
          avail     = int'(decl_total) - pos + 3;
          if (phdr[31:16] < PHDR_SIZE || int'(phdr[31:16]) > avail) begin
            err_code = ST_BAD_PLEN;
          end else begin
            bytes_left = phdr[31:16] - PHDR_SIZE;
            data_pos   = 16'd0;
            queue_token(form_token(KIND_HDR, msg_id, phdr[15:0], bytes_left,
                                   8'd0, 16'd0, 1'b0, ST_OK, 1'b0));
          end
        end
      end
    end

    // Saturate the byte count on very long frames
    if (seen_count != 16'hFFFF) seen_count = seen_count + 16'd1;

    if (last) begin
      mid = msg_id;
      if (seen_count < HDR_SIZE) begin
        st  = ST_SHORT;
        mid = 16'd0;
      end else if (seen_marker != start_word) begin
        st = ST_BAD_MARKER;
      end else if (decl_total < HDR_SIZE || decl_total > seen_count) begin
        st = ST_BAD_LEN;
      end else begin
        st = err_code;
      end
      queue_token(form_token(KIND_STATUS, mid, 16'd0, 16'd0, 8'd0, 16'd0,
                             1'b0, st, 1'b1));
      seen_count  = '0;
      seen_marker = '0;
      decl_total  = '0;
      msg_id      = '0;
      phdr        = '0;
      phdr_fill   = '0;
      bytes_left  = '0;
      data_pos    = '0;
      err_code    = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Sample both handshakes: check the token, then predict from the byte
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (tokens_due.size() == 0) begin
          report_mismatch("token with none due, kind", out_token_kind, 0);
        end else begin
          token_seen = tokens_due.pop_front();
          if (out_token_kind !== token_seen.kind)
            report_mismatch("token_kind", out_token_kind, token_seen.kind);
          if (out_message_id !== token_seen.message_id)
            report_mismatch("message_id", out_message_id, token_seen.message_id);
          if (out_param_id !== token_seen.param_id)
            report_mismatch("param_id", out_param_id, token_seen.param_id);
          if (out_param_data_length !== token_seen.param_data_length)
            report_mismatch("param_data_length", out_param_data_length,
                            token_seen.param_data_length);
          if (out_param_byte !== token_seen.param_byte)
            report_mismatch("param_byte", out_param_byte, token_seen.param_byte);
          if (out_byte_index !== token_seen.byte_index)
            report_mismatch("byte_index", out_byte_index, token_seen.byte_index);
          if (out_param_last !== token_seen.param_last)
            report_mismatch("param_last", out_param_last, token_seen.param_last);
          if (out_status !== token_seen.status)
            report_mismatch("status", out_status, token_seen.status);
          if (out_frame_done !== token_seen.frame_done)
            report_mismatch("frame_done", out_frame_done, token_seen.frame_done);
        end
      end
      if (in_valid && !in_stall) begin
        parse_byte(in_data_byte, in_frame_last);
        byte_taken = 1'b1;
      end
    end
  end

  // Byte driver: hold the payload until taken, then send the next or idle
  always @(negedge clk) begin
    if (rst_n && (!in_valid || byte_taken)) begin
      byte_taken = 1'b0;
      if (tx_gap_left > 0) begin
        tx_gap_left--;
        in_valid <= 1'b0;
      end else if (bytes_pending.size() == 0 ||
                   (bytes_pending[0].drain && tokens_due.size() != 0)) begin
        in_valid <= 1'b0;
      end else if (!tx_calm && $urandom_range(0, 7) == 0) begin
        tx_gap_left = $urandom_range(0, 10);
        in_valid <= 1'b0;
      end else begin
        byte_to_send = bytes_pending.pop_front();
        in_valid      <= 1'b1;
        in_data_byte  <= byte_to_send.data;
        in_frame_last <= byte_to_send.last;
      end
    end
  end

  // Long receiver hold-off, counted here and merged into the stall below
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= 120;
    end
  end

  // Receiver stall bursts
  always @(negedge clk) begin
    if (rx_gap_left > 0) begin
      rx_gap_left--;
      rx_burst = 1'b1;
    end else if (!rx_calm && $urandom_range(0, 7) == 0) begin
      rx_gap_left = $urandom_range(0, 10);
      rx_burst = 1'b1;
    end else begin
      rx_burst = 1'b0;
    end
    out_stall <= rx_burst || (hold_left != 0);
  end

  // Append one byte to the frame under construction
  task automatic add_frame_byte(input logic [7:0] b);
    frame_buf = {frame_buf, b};
  endtask

  // Move the built frame into the send queue, last flag on its final byte
  task automatic commit_frame(input bit drain);
    byte_item_t it;
    foreach (frame_buf[i]) begin
      it.data  = frame_buf[i];
      it.last  = (i == frame_buf.size() - 1);
      it.drain = drain && (i == 0);
      bytes_pending = {bytes_pending, it};
    end
    frame_buf = {};
  endtask

  task automatic push_word(input logic [15:0] w);
    add_frame_byte(w[15:8]);
    add_frame_byte(w[7:0]);
  endtask

  // Build one random frame, mostly well-formed, else broken in one way
  task automatic queue_random_frame(ref int budget);
    int          pick;
    int          dlen;
    int          fill;
    int          decl;
    logic [15:0] flip;
    logic [15:0] ptotal;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      // short frame
      repeat ($urandom_range(1, 5)) add_frame_byte(8'($urandom));
    end else if (pick >= 96) begin
      // noise
      repeat ($urandom_range(1, 20)) add_frame_byte(8'($urandom));
    end else begin
      push_word(start_word);
      push_word(16'd0);
      push_word(16'($urandom));
      repeat ($urandom_range(0, 3)) begin
        dlen = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        push_word(16'(dlen + 4));
        push_word(16'($urandom));
        repeat (dlen) add_frame_byte(8'($urandom));
      end
      if (pick >= 84 && pick < 90) begin
        // truncated parameter header at the end of the body
        repeat ($urandom_range(1, 3)) add_frame_byte(8'($urandom));
      end else if (pick >= 90) begin
        // parameter length below four or beyond the body
        fill   = $urandom_range(0, 6);
        ptotal = $urandom_range(0, 1) ? 16'($urandom_range(0, 3))
                                      : 16'(4 + fill + $urandom_range(1, 12));
        push_word(ptotal);
        push_word(16'($urandom));
        repeat (fill) add_frame_byte(8'($urandom));
      end
      decl = frame_buf.size();
      if (pick >= 72 && pick < 84) begin
        // declared total below the header size or beyond the frame
        decl = $urandom_range(0, 1) ? $urandom_range(0, 5) : decl + $urandom_range(1, 8);
      end
      frame_buf[2] = 8'(decl >> 8);
      frame_buf[3] = 8'(decl);
      if (pick >= 66 && pick < 72) begin
        flip = 16'($urandom_range(1, 65535));
        frame_buf[0] = frame_buf[0] ^ flip[15:8];
        frame_buf[1] = frame_buf[1] ^ flip[7:0];
      end
      // bytes past the declared total
      if ((pick < 72 || pick >= 84) && $urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 4)) add_frame_byte(8'($urandom));
    end
    budget -= frame_buf.size();
    commit_frame(!tx_calm && $urandom_range(0, 9) == 0);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (bytes_pending.size() != 0 || in_valid || tokens_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start_word(input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    start_word = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int items);
    int budget;
    budget = items;
    while (budget > 0) queue_random_frame(budget);
    wait_idle();
  endtask

  // Run limit
  initial begin
    #20000000;
    $display("control_message_tlv_parser_tb failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames under the reset start word
    frame_buf = {8'hFF};
    commit_frame(1'b0);
    frame_buf = {8'h40, 8'h40, 8'h00, 8'h06, 8'hFF, 8'hFF};
    commit_frame(1'b0);
    frame_buf = {8'h40, 8'h40, 8'h00, 8'h0B, 8'h00, 8'h00,
                 8'h00, 8'h05, 8'hFF, 8'hFF, 8'h00, 8'hA5};
    commit_frame(1'b0);
    frame_buf = {8'h40, 8'h40, 8'h00, 8'h08, 8'h12, 8'h34, 8'h80, 8'h7F};
    commit_frame(1'b1);
    wait_idle();

    run_random(100);
    write_start_word(16'h0000);
    run_random(150);

    // Hold the receiver off while bytes keep coming
    write_start_word(16'hFFFF);
    tx_calm = 1'b1;
    begin
      int budget;
      budget = 60;
      while (budget > 0) queue_random_frame(budget);
    end
    hold_req = 1'b1;
    wait_idle();
    tx_calm = 1'b0;
    run_random(100);

    repeat (4) begin
      write_start_word(16'($urandom));
      run_random(120);
    end

    // Closing stretch with no idling on either side
    write_start_word(16'($urandom));
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    run_random(100);

    repeat (10) @(posedge clk);
    if (mismatches == 0 && tokens_due.size() == 0) begin
      $display("control_message_tlv_parser_tb passed");
    end else begin
      $display("control_message_tlv_parser_tb failed");
    end
    $finish;
  end

endmodule
